>>> design/mdb_pkg.sv
// Shared constants, types and the log table for the magnitude to decibel converter.
package mdb_pkg;

  localparam int MagWidth   = 32;
  localparam int NormWidth  = 29;
  localparam int LevelWidth = 10;
  localparam int StatWidth  = 2;

  localparam logic [NormWidth-1:0] LIMIT_VALUE = 29'h1FFF_FFFF;
  localparam int BASE_LEVEL   = 1440;
  localparam int STEP_LEVEL   = 60;
  localparam int TableDepth   = 65;
  localparam int TableIdxW    = 7;
  localparam int TableDataW   = 6;
  localparam int LevelMax     = 720;

  localparam logic [StatWidth-1:0] STATUS_OK  = 2'd0;
  localparam logic [StatWidth-1:0] STATUS_NEG = 2'd1;
  localparam logic [StatWidth-1:0] STATUS_SAT = 2'd2;

  // floor(200*log10(1+n/64)) for n = 0..64.
  localparam logic [TableDataW-1:0] LOG_TABLE [0:TableDepth-1] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
    6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
    6'd42, 6'd43, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd50, 6'd51, 6'd52, 6'd53, 6'd53, 6'd54, 6'd55, 6'd56, 6'd56,
    6'd57, 6'd58, 6'd58, 6'd59, 6'd60
  };

  typedef struct packed {
    logic [LevelWidth-1:0] level;
    logic [StatWidth-1:0]  status;
  } mdb_result_t;

endpackage

>>> design/mdb_level.sv
// Combinational conversion of one squared magnitude to a level and a status code.
module mdb_level import mdb_pkg::*; (
  input  logic signed [MagWidth-1:0] magnitude,
  output mdb_result_t                result
);

  logic                    is_neg;
  logic                    is_zero;
  logic                    is_big;
  logic                    is_limit;
  logic [NormWidth-1:0]    v;
  logic [31:0]             w0, w1, w2, w3, w4, w5;
  logic [4:0]              lz;
  logic [4:0]              shifts;
  logic [TableIdxW-1:0]    idx;
  logic [TableIdxW-1:0]    idx_lim;
  logic signed [11:0]      total;

  assign is_neg  = magnitude[MagWidth-1];
  assign is_zero = (magnitude == '0);
  assign is_big  = !is_neg && (magnitude[MagWidth-2:NormWidth] != '0);
  assign v       = is_big ? LIMIT_VALUE : magnitude[NormWidth-1:0];
  assign is_limit = (v == LIMIT_VALUE);

  // Leading-zero count and normalization by binary search, five steps.
  always_comb begin
    w0 = {v, 3'b000};
    lz = '0;
    if (w0[31:16] == '0) begin
      w1 = {w0[15:0], 16'h0000};
      lz[4] = 1'b1;
    end else begin
      w1 = w0;
    end
    if (w1[31:24] == '0) begin
      w2 = {w1[23:0], 8'h00};
      lz[3] = 1'b1;
    end else begin
      w2 = w1;
    end
    if (w2[31:28] == '0) begin
      w3 = {w2[27:0], 4'h0};
      lz[2] = 1'b1;
    end else begin
      w3 = w2;
    end
    if (w3[31:30] == '0) begin
      w4 = {w3[29:0], 2'b00};
      lz[1] = 1'b1;
    end else begin
      w4 = w3;
    end
    if (!w4[31]) begin
      w5 = {w4[30:0], 1'b0};
      lz[0] = 1'b1;
    end else begin
      w5 = w4;
    end
  end

  // The all-ones limit already meets the threshold; anything else needs one
  // doubling past its leading one, so the six bits below it form the index.
  assign shifts  = is_limit ? 5'd0 : lz + 5'd1;
  assign idx     = is_limit ? '0 : {1'b0, w5[30:25]} + 7'd1;
  assign idx_lim = (idx > 7'(TableDepth - 1)) ? 7'(TableDepth - 1) : idx;

  assign total = 12'(BASE_LEVEL) - 12'(shifts * 11'(STEP_LEVEL))
               + 12'(LOG_TABLE[idx_lim]);

  always_comb begin
    if (is_neg) begin
      result.level  = '0;
      result.status = STATUS_NEG;
    end else if (is_zero) begin
      result.level  = '0;
      result.status = STATUS_OK;
    end else begin
      result.level  = total[11] ? '0 : total[10:1];
      result.status = is_big ? STATUS_SAT : STATUS_OK;
    end
  end

endmodule

>>> design/magnitude_to_decibel_converter_top.sv
// Top level of the magnitude to decibel converter: input register, conversion, result register.
//
// The block takes one signed 32-bit squared magnitude per request on the input
// channel (in_valid, in_stall, magnitude) and returns one result per request on
// the output channel (out_valid, out_stall, level_db_x10, status). The level is
// in tenths of a decibel, 0 to 720. Status reports a negative input forced to
// zero or an input above 2^29-1 that was saturated.
// Each request is captured in an input register, converted by a short
// normalize, table lookup and add path, and held in a result register, so a
// result reaches the outputs once it moves from the input register into the
// result register, and stays there until the receiver takes it. One request is
// accepted every cycle while the output is drained; throughput is set by the
// single-pass conversion path between the two registers.
// When the receiver stalls, the result register holds its value and the input
// register fills; only when both are full does in_stall rise, so no request is
// lost or repeated. Reset empties both registers and holds in_stall high while
// it is asserted.
module magnitude_to_decibel_converter_top import mdb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [MagWidth-1:0] magnitude,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LevelWidth-1:0]      level_db_x10,
  output logic [StatWidth-1:0]       status
);

  logic                       s1_valid;
  logic signed [MagWidth-1:0] s1_mag;
  logic                       in_take;
  logic                       out_load;
  mdb_result_t                conv;
  mdb_result_t                res;

  // The result register loads a held request whenever it is empty or being drained.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = rst || (s1_valid && !out_load);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mag <= magnitude;
    end
  end

  mdb_level u_level (
    .magnitude (s1_mag),
    .result    (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= conv;
    end
  end

  assign level_db_x10 = res.level;
  assign status       = res.status;

  // A negative input always comes out as level zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_NEG) |-> (level_db_x10 == '0))
    else $error("negative input produced a nonzero level");

  // A saturated input always lands on the top level.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_SAT) |-> (level_db_x10 == 10'(LevelMax)))
    else $error("saturated input did not give the top level");

  // The level never exceeds its documented range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_db_x10 <= 10'(LevelMax)))
    else $error("level out of range");

  // An accepted request always occupies the input register next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted request was dropped");

endmodule

>>> test/tb_magnitude_to_decibel_converter_top.sv
// Self-checking testbench for the magnitude to decibel converter top level.
`timescale 1ns / 100ps

// The run drives signed squared magnitudes into the converter and checks every
// returned level and status against an in-bench prediction of the conversion.
//
// The prediction follows the block's arithmetic directly:
// - Negative inputs give level 0 and a negative status.
// - Zero gives level 0 with an ok status.
// - Values above 2^29-1 are saturated and flagged.
// - Everything else is doubled up to the normalization limit, losing 60 per
//   doubling from 1440, then refined by a 65-entry fraction table and halved.
//
// A single monitor process records each accepted request's expected result at
// the edge where the request is taken, and checks results in order as they are
// taken on the output side. The sender and the receiver insert random idle
// cycles in three mixes. One phase holds the receiver off for a long stretch
// so that the block fills up and pushes back on its input.
//
// A watchdog ends the run when no request and no result moves for too long.
module tb_magnitude_to_decibel_converter_top;
  import mdb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 8;

  // Normalization constants of the conversion.
  localparam logic [31:0] NORM_LIMIT        = 32'h1FFF_FFFF;
  localparam int          FULL_SCALE_X10    = 1440;
  localparam int          DOUBLING_STEP_X10 = 60;
  localparam int          FRACTION_SHIFT    = 23;
  localparam int          FRACTION_OFFSET   = 63;
  localparam int          FRACTION_MAX      = 64;

  // floor(200*log10(1+n/64)) for n = 0..64, entry n at bits [(64-n)*6 +: 6].
  localparam logic [65*6-1:0] FRACTION_DB_X10 = {
    6'd0,  6'd1,  6'd2,  6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd14, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
    6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41,
    6'd42, 6'd43, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49,
    6'd50, 6'd50, 6'd51, 6'd52, 6'd53, 6'd53, 6'd54, 6'd55, 6'd56, 6'd56,
    6'd57, 6'd58, 6'd58, 6'd59, 6'd60
  };

  typedef struct packed {
    logic [LevelWidth-1:0] level;
    logic [StatWidth-1:0]  status;
  } level_result_t;

  // All block inputs start at known values; reset is high from time zero.
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic signed [MagWidth-1:0] magnitude = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [LevelWidth-1:0]      level_db_x10;
  logic [StatWidth-1:0]       status;

  // Idle percentages for the two sides, changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The hold-off phase bumps the request count; the receiver serves it.
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;

  level_result_t expected_levels[$];
  level_result_t next_level;
  int error_count     = 0;
  int requests_taken  = 0;
  int results_checked = 0;
  int quiet_cycles    = 0;
  int stalled_offers  = 0;

  magnitude_to_decibel_converter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .magnitude    (magnitude),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level_db_x10 (level_db_x10),
    .status       (status)
  );

  always #10 clk = ~clk;

  // Expected level and status for one squared magnitude.
  function automatic level_result_t predict_level(input logic signed [31:0] mag);
    logic [31:0]   norm;
    logic [31:0]   frac_idx;
    int            total;
    level_result_t r;
    r.level  = '0;
    r.status = STATUS_OK;
    if (mag < 0) begin
      r.status = STATUS_NEG;
      return r;
    end
    if (mag == 0) begin
      return r;
    end
    norm = mag;
    if (norm > NORM_LIMIT) begin
      norm     = NORM_LIMIT;
      r.status = STATUS_SAT;
    end
    total = FULL_SCALE_X10;
    while (norm < NORM_LIMIT) begin
      norm  = norm << 1;
      total = total - DOUBLING_STEP_X10;
    end
    frac_idx = (norm >> FRACTION_SHIFT) - FRACTION_OFFSET;
    if (frac_idx > FRACTION_MAX) begin
      frac_idx = FRACTION_MAX;
    end
    total = total + int'(FRACTION_DB_X10[(FRACTION_MAX - frac_idx)*6 +: 6]);
    // Halve for a squared input; a negative total clamps to silence.
    if (total > 0) begin
      r.level = total[LevelWidth:1];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_checked);
    error_count++;
  endtask

  // Monitor: check each accepted result against the oldest expectation, then
  // record the expectation for a request accepted at this edge. Results pass
  // the input and result registers, so no request meets its own result here.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("result with no request pending", int'(level_db_x10), -1);
        end else begin
          next_level = expected_levels.pop_front();
          if (level_db_x10 !== next_level.level) begin
            report_mismatch("level_db_x10", int'(level_db_x10), int'(next_level.level));
          end
          if (status !== next_level.status) begin
            report_mismatch("status", int'(status), int'(next_level.status));
          end
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        expected_levels.push_back(predict_level(magnitude));
        requests_taken++;
      end
      if (in_valid && in_stall) begin
        stalled_offers++;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any cycle that moves a request or a result resets the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles, %0d results outstanding",
                 quiet_cycles, expected_levels.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one request and return once it has been accepted. Valid is lowered
  // only while idling, so it never drops and rises again within one step.
  task automatic send_magnitude(input logic signed [31:0] mag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    magnitude <= mag;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // A random magnitude drawn from the classes the conversion treats apart.
  function automatic logic signed [31:0] random_magnitude();
    logic [31:0] v;
    int          bits;
    case ($urandom_range(9))
      0: begin
        v     = $urandom;
        v[31] = 1'b1;
      end
      1: v = '0;
      2, 3, 4: begin
        // Random bit length so every normalization depth is reached.
        bits = $urandom_range(29, 1);
        v    = ($urandom & ((32'd1 << bits) - 1)) | (32'd1 << (bits - 1));
      end
      5: v = NORM_LIMIT + $urandom_range(16) - 8;
      6: begin
        v     = $urandom;
        v[31] = 1'b0;
        v[29] = v[29] | ~(v[30]);
      end
      7: v = $urandom_range(64, 1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic signed [31:0] edge_values[$];
    edge_values = '{
      32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd32, 32'sd33, 32'sd4096,
      -32'sd1, 32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFF, 32'sh4000_0000,
      32'sh1FFF_FFFF, 32'sh2000_0000, 32'sh1FFF_FFFE, 32'sh1000_0000,
      32'sh0FFF_FFFF, 32'sh0FFF_FFFE, 32'sh1F80_0000, 32'sh1FBF_FFFF,
      32'sh00FF_FFFF, 32'shFFFF_FF00, 32'sh5555_5555, 32'shAAAA_AAAA
    };
    send_idle_pct = 33;
    recv_idle_pct = 49;
    foreach (edge_values[i]) begin
      send_magnitude(edge_values[i]);
    end
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      send_magnitude(random_magnitude());
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // input and result registers fill and the block raises in_stall.
  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    holds_requested++;
    repeat (30) begin
      send_magnitude(random_magnitude());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(420, 33, 49);
    test_receiver_hold_off();
    test_random(420, 49, 33);
    test_random(390, 0, 0);
    in_valid <= 1'b0;

    // Drain whatever is still in flight; the watchdog bounds this wait.
    while (expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0) begin
      report_mismatch("results never returned", expected_levels.size(), 0);
    end

    $display("Summary: %0d requests and %0d results checked across edge values, three",
             requests_taken, results_checked);
    $display("stall mixes and a %0d-cycle receiver hold-off (%0d stalled offers).",
             HOLD_OFF_CYCLES, stalled_offers);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mdb_pkg.sv
design/mdb_level.sv
design/magnitude_to_decibel_converter_top.sv
test/tb_magnitude_to_decibel_converter_top.sv
